// ===== design/sha_pkg.sv =====
package sha_pkg;

    localparam int unsigned Rounds = 64;

    typedef enum logic [2:0] {
        ST_GATHER,
        ST_PAD,
        ST_LOAD,
        ST_ROUND,
        ST_FOLD,
        ST_EMIT
    } t_state;

    // commands from the controller to the datapath
    typedef struct packed {
        logic       take_byte;
        logic       pad_write;
        logic [5:0] pad_addr;
        logic [7:0] pad_data;
        logic       load;
        logic       round;
        logic [5:0] round_idx;
        logic       fold;
        logic       clear;
        logic [2:0] emit_idx;
    } t_cmd;

    function automatic logic [31:0] round_k(input logic [5:0] idx);
        logic [31:0] k [64];
        k = '{
            32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
            32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
            32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
            32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
            32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
            32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
            32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
            32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
            32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
            32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
            32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
            32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
            32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
            32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
            32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
            32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
        };
        return k[idx];
    endfunction

    function automatic logic [31:0] init_hash(input logic [2:0] idx);
        logic [31:0] h [8];
        h = '{
            32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
            32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
        };
        return h[idx];
    endfunction

endpackage

// ===== design/sha_datapath.sv =====
module sha_datapath
    import sha_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    input  logic [7:0]  i_data_byte,
    input  logic [5:0]  i_wr_addr,
    output logic [63:0] o_message_bits,
    output logic [31:0] o_digest_word
);

    logic [31:0] r_w [16];
    logic [31:0] r_h [8];
    logic [31:0] r_v [8];
    logic [63:0] r_bits;

    logic [31:0] w_new, w_cur, s0, s1, t1, t2, e, a;

    // count message length in bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            r_bits <= '0;
        end else if (i_cmd.take_byte) begin
            r_bits <= r_bits + 64'd8;
        end
    end

    // message schedule: sliding window of sixteen words
    always_comb begin
        s0 = {r_w[1][6:0], r_w[1][31:7]} ^ {r_w[1][17:0], r_w[1][31:18]} ^ (r_w[1] >> 3);
        s1 = {r_w[14][16:0], r_w[14][31:17]} ^ {r_w[14][18:0], r_w[14][31:19]}
            ^ (r_w[14] >> 10);
        w_new = s1 + r_w[9] + s0 + r_w[0];
        w_cur = r_w[0];
        e = r_v[4];
        a = r_v[0];
        t1 = r_v[7] + ({e[5:0], e[31:6]} ^ {e[10:0], e[31:11]} ^ {e[24:0], e[31:25]})
            + ((e & r_v[5]) ^ (~e & r_v[6])) + round_k(i_cmd.round_idx) + w_cur;
        t2 = ({a[1:0], a[31:2]} ^ {a[12:0], a[31:13]} ^ {a[21:0], a[31:22]})
            + ((a & r_v[1]) ^ (a & r_v[2]) ^ (r_v[1] & r_v[2]));
    end

    // gather bytes and padding straight into the schedule window (big-endian
    // within each word), then load, step one round
    always_ff @(posedge i_clk) begin
        if (i_cmd.take_byte) begin
            r_w[i_wr_addr[5:2]][{~i_wr_addr[1:0], 3'b000} +: 8] <= i_data_byte;
        end else if (i_cmd.pad_write) begin
            r_w[i_cmd.pad_addr[5:2]][{~i_cmd.pad_addr[1:0], 3'b000} +: 8] <= i_cmd.pad_data;
        end else if (i_cmd.load) begin
            for (int t = 0; t < 8; t++) begin
                r_v[t] <= r_h[t];
            end
        end else if (i_cmd.round) begin
            for (int t = 0; t < 15; t++) begin
                r_w[t] <= r_w[t+1];
            end
            r_w[15] <= w_new;
            r_v[0] <= t1 + t2;
            r_v[1] <= r_v[0];
            r_v[2] <= r_v[1];
            r_v[3] <= r_v[2];
            r_v[4] <= r_v[3] + t1;
            r_v[5] <= r_v[4];
            r_v[6] <= r_v[5];
            r_v[7] <= r_v[6];
        end
    end

    // fold into chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            for (int t = 0; t < 8; t++) begin
                r_h[t] <= init_hash(3'(t));
            end
        end else if (i_cmd.fold) begin
            for (int t = 0; t < 8; t++) begin
                r_h[t] <= r_h[t] + r_v[t];
            end
        end
    end

    assign o_message_bits = r_bits;
    assign o_digest_word  = r_h[i_cmd.emit_idx];

endmodule

// ===== design/sha_ctrl.sv =====
module sha_ctrl
    import sha_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_byte_valid,
    input  logic        i_last_byte,
    input  logic [63:0] i_message_bits,
    output logic [5:0]  o_wr_addr,
    output t_cmd        o_cmd,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_word_index,
    output logic        o_last_word
);

    t_state     r_state, n_state;
    logic [5:0] r_fill, n_fill;
    logic [5:0] r_cnt, n_cnt;
    logic       r_final, n_final;
    logic       r_two, n_two;
    logic       r_padded;
    logic       accept;

    assign accept = i_valid && !o_stall;
    assign o_wr_addr = r_fill;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_GATHER;
            r_fill  <= '0;
            r_cnt   <= '0;
            r_final <= 1'b0;
            r_two   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            r_cnt   <= n_cnt;
            r_final <= n_final;
            r_two   <= n_two;
        end
    end

    always_comb begin
        n_state = r_state;
        n_fill  = r_fill;
        n_cnt   = r_cnt;
        n_final = r_final;
        n_two   = r_two;
        o_cmd   = '0;
        o_cmd.round_idx = r_cnt;
        o_cmd.emit_idx  = r_cnt[2:0];
        o_stall     = 1'b1;
        o_out_valid = 1'b0;
        unique case (r_state)
            ST_GATHER: begin
                o_stall = 1'b0;
                if (accept) begin
                    o_cmd.take_byte = i_byte_valid;
                    if (i_byte_valid) begin
                        n_fill = r_fill + 6'd1;
                    end
                    n_final = i_last_byte;
                    if (i_byte_valid && r_fill == 6'd63) begin
                        n_state = ST_LOAD;
                        n_two   = 1'b0;
                    end else if (i_last_byte) begin
                        n_state = ST_PAD;
                        n_cnt   = n_fill;
                        n_two   = 1'b0;
                    end
                end
            end
            // write 0x80 (first block), zeros, then the length (last block), one byte per cycle
            ST_PAD: begin
                o_cmd.pad_write = 1'b1;
                o_cmd.pad_addr  = r_cnt;
                if (r_cnt == r_fill && !r_two) begin
                    o_cmd.pad_data = 8'h80;
                end else if (r_cnt >= 6'd56 && (r_fill < 6'd56 || r_two)) begin
                    o_cmd.pad_data = i_message_bits[8*(7-r_cnt[2:0]) +: 8];
                end else begin
                    o_cmd.pad_data = 8'h00;
                end
                n_cnt = r_cnt + 6'd1;
                if (r_cnt == 6'd63) begin
                    n_state = ST_LOAD;
                end
            end
            ST_LOAD: begin
                o_cmd.load = 1'b1;
                n_cnt   = '0;
                n_state = ST_ROUND;
            end
            ST_ROUND: begin
                o_cmd.round = 1'b1;
                n_cnt = r_cnt + 6'd1;
                if (r_cnt == 6'(Rounds - 1)) begin
                    n_state = ST_FOLD;
                end
            end
            ST_FOLD: begin
                o_cmd.fold = 1'b1;
                n_cnt = '0;
                if (!r_final) begin
                    n_state = ST_GATHER;
                end else if (r_fill != 6'd0 && !r_two && r_fill >= 6'd56) begin
                    // length spills into a second block
                    n_two   = 1'b1;
                    n_state = ST_PAD;
                end else if (r_fill == 6'd0 && !r_two && !r_padded) begin
                    n_state = ST_PAD;
                end else begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                o_out_valid = 1'b1;
                if (!i_out_stall) begin
                    n_cnt = r_cnt + 6'd1;
                    if (r_cnt[2:0] == 3'd7) begin
                        o_cmd.clear = 1'b1;
                        n_state = ST_GATHER;
                        n_fill  = '0;
                        n_final = 1'b0;
                        n_two   = 1'b0;
                        n_cnt   = '0;
                    end
                end
            end
            default: n_state = ST_GATHER;
        endcase
    end

    // a fold on a final item is the padded block unless the fill was a full block
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_padded <= 1'b0;
        end else if (r_state == ST_PAD) begin
            r_padded <= 1'b1;
        end else if (r_state == ST_GATHER) begin
            r_padded <= 1'b0;
        end
    end

    assign o_word_index = r_cnt[2:0];
    assign o_last_word  = (r_cnt[2:0] == 3'd7);

endmodule

// ===== design/sha256_stream_hasher.sv =====
// SHA-256 over a byte stream. Each accepted word carries an optional message
// byte and an end flag; while gathering, one word is taken per cycle. A 64th
// byte stalls the input while the block is compressed (load, 64 rounds, fold).
// An end flag then writes padding one byte per cycle from the fill point to the
// end of the block, from byte 0 right after a full block, and compresses it;
// when more than 55 bytes are pending a second padded block follows. The input
// stays stalled during that work and while the digest leaves as eight 32-bit
// words, word 0 first, one per cycle unless stalled; then the hasher restarts
// for the next message.
module sha256_stream_hasher
    import sha_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_byte_valid,
    input  logic        i_last_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_word_index,
    output logic        o_last_word
);

    t_cmd        cmd;
    logic [63:0] message_bits;
    logic [5:0]  wr_addr;

    sha_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_byte_valid   (i_byte_valid),
        .i_last_byte    (i_last_byte),
        .i_message_bits (message_bits),
        .o_wr_addr      (wr_addr),
        .o_cmd          (cmd),
        .o_out_valid    (o_valid),
        .i_out_stall    (i_stall),
        .o_word_index   (o_word_index),
        .o_last_word    (o_last_word)
    );

    sha_datapath u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_data_byte    (i_data_byte),
        .i_wr_addr      (wr_addr),
        .o_message_bits (message_bits),
        .o_digest_word  (o_digest_word)
    );

endmodule
